// File: src/mfna_pkg.sv
// Package for the mesh face normal assembler: payload structs, command codes,
// size constants and the queue entry type shared by the front and back parts.
// No dependencies.
package mfna_pkg;

	localparam int MAX_VERTICES_DEF = 16384;
	localparam int COORD_BITS_DEF   = 24;
	localparam int NORMAL_BITS_DEF  = 16;
	localparam int INDEX_BITS       = 15;
	localparam int CW               = 24;
	localparam int NW               = 16;

	localparam logic [1:0] CMD_VERTEX = 2'd0;
	localparam logic [1:0] CMD_FACE   = 2'd1;
	localparam logic [1:0] CMD_NEW    = 2'd2;
	localparam logic [1:0] CMD_QUERY  = 2'd3;

	typedef struct packed {
		logic [1:0]             cmd;
		logic signed [CW-1:0]   coord_x;
		logic signed [CW-1:0]   coord_y;
		logic signed [CW-1:0]   coord_z;
		logic [INDEX_BITS-1:0]  index_a;
		logic [INDEX_BITS-1:0]  index_b;
		logic [INDEX_BITS-1:0]  index_c;
	} in_item_t;

	typedef struct packed {
		logic signed [CW-1:0] vert_x;
		logic signed [CW-1:0] vert_y;
		logic signed [CW-1:0] vert_z;
		logic signed [NW-1:0] norm_x;
		logic signed [NW-1:0] norm_y;
		logic signed [NW-1:0] norm_z;
		logic                 last;
		logic                 status;
		logic signed [CW-1:0] center_x;
		logic signed [CW-1:0] center_y;
		logic signed [CW-1:0] center_z;
	} out_item_t;

	// Classified request handed from the front part to the back part.
	localparam logic [1:0] JOB_FACE  = 2'd0;
	localparam logic [1:0] JOB_BAD   = 2'd1;
	localparam logic [1:0] JOB_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]           kind;
		logic [INDEX_BITS:0]  ia;
		logic [INDEX_BITS:0]  ib;
		logic [INDEX_BITS:0]  ic;
		logic signed [CW-1:0] cen_x;
		logic signed [CW-1:0] cen_y;
		logic signed [CW-1:0] cen_z;
	} job_t;

endpackage

// File: src/mesh_face_normal_assembler_unit.sv
// Top level of the mesh face normal assembler: front part, job queue and back part.
// Uses mfna_pkg, mfna_front, mfna_queue, mfna_back.
//
// Usage: requests enter on in_valid/in_ready/in_data (in_item_t), results leave on
// out_valid/out_ready/out_data (out_item_t). A vertex request writes the vertex
// table and bounding box. New-mesh clears the count and is held until the job
// queue is empty, so no queued face reads a reused entry. Neither gives a result.
// Face and query requests are queued (two deep) for the back part. A query or a
// bad-index face gives one result. A good face passes through the back part in
// order: start, the table reads, differences and reduction, the products on the
// shared multiplier, cross product and reduction, the squares, the bit-serial
// square root and the three restoring divides; then it gives three results, one
// per vertex, with last on the third. The back part takes the next face or query
// only after the last result of the current one has entered the result register.
// Reset clears the count, the box and the queue; the vertex table is not cleared.
// A stalled receiver holds the result register; the queue then fills and face,
// query and new-mesh requests back up, while vertex requests still flow.
module mesh_face_normal_assembler_unit #(
	parameter int MAX_VERTICES = mfna_pkg::MAX_VERTICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mfna_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mfna_pkg::out_item_t out_data
);
	import mfna_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);

	job_t            fj, qj;
	logic            fv, fr, qv, qr, wen;
	logic [AW-1:0]   wad;
	logic [3*CW-1:0] wdt;

	mfna_front #(.MAX_VERTICES(MAX_VERTICES), .AW(AW)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.job_valid(fv), .job_ready(fr), .job(fj), .tbl_busy(qv),
		.wr_en(wen), .wr_addr(wad), .wr_data(wdt)
	);

	mfna_queue #(.DEPTH(2)) u_queue (
		.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
		.rd_valid(qv), .rd_ready(qr), .rd_data(qj)
	);

	mfna_back #(.AW(AW), .MAX_VERTICES(MAX_VERTICES)) u_back (
		.clk, .arst_n, .wr_en(wen), .wr_addr(wad), .wr_data(wdt),
		.job_valid(qv), .job_ready(qr), .job(qj),
		.out_valid, .out_ready, .out_data
	);
endmodule

// File: src/mfna_front.sv
// Front part: accepts requests, stores vertices, keeps the bounding box and
// classifies faces and queries into jobs. Uses mfna_pkg.
module mfna_front #(
	parameter int MAX_VERTICES = 16384,
	parameter int AW = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mfna_pkg::in_item_t in_data,
	output logic              job_valid,
	input  logic              job_ready,
	output mfna_pkg::job_t    job,
	// high while a queued face may still read the vertex table
	input  logic              tbl_busy,
	// vertex table write port
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output logic [3*mfna_pkg::CW-1:0] wr_data
);
	import mfna_pkg::*;

	localparam int CNTW = $clog2(MAX_VERTICES + 1);

	logic [CNTW-1:0]      count_q;
	logic signed [CW-1:0] min_x_q, max_x_q, min_y_q, max_y_q, min_z_q, max_z_q;
	logic                 empty_q;
	logic                 acc, is_bad, need_job;
	logic [INDEX_BITS:0]  ca, cb, cc;
	logic signed [CW:0]   sx, sy, sz;

	assign acc = in_valid && in_ready;
	assign need_job = (in_data.cmd == CMD_FACE) || (in_data.cmd == CMD_QUERY);
	// a job command needs queue room; new-mesh waits until queued faces have
	// read their vertices, since later vertices reuse the same entries
	assign in_ready = (in_data.cmd == CMD_NEW) ? !tbl_busy : (!need_job || job_ready);
	assign job_valid = in_valid && need_job;

	assign ca = {1'b0, in_data.index_a};
	assign cb = {1'b0, in_data.index_b};
	assign cc = {1'b0, in_data.index_c};

	always_comb begin
		is_bad = 1'b0;
		if (in_data.index_a == '0 || INDEX_BITS'(CNTW'(in_data.index_a)) != in_data.index_a
			|| CNTW'(in_data.index_a) > count_q)
			is_bad = 1'b1;
		if (in_data.index_b == '0 || INDEX_BITS'(CNTW'(in_data.index_b)) != in_data.index_b
			|| CNTW'(in_data.index_b) > count_q)
			is_bad = 1'b1;
		if (in_data.index_c == '0 || INDEX_BITS'(CNTW'(in_data.index_c)) != in_data.index_c
			|| CNTW'(in_data.index_c) > count_q)
			is_bad = 1'b1;
	end

	assign sx = ({min_x_q[CW-1], min_x_q} + {max_x_q[CW-1], max_x_q}) >>> 1;
	assign sy = ({min_y_q[CW-1], min_y_q} + {max_y_q[CW-1], max_y_q}) >>> 1;
	assign sz = ({min_z_q[CW-1], min_z_q} + {max_z_q[CW-1], max_z_q}) >>> 1;

	always_comb begin
		job.kind  = (in_data.cmd == CMD_QUERY) ? JOB_QUERY : (is_bad ? JOB_BAD : JOB_FACE);
		job.ia    = ca - 1'b1;
		job.ib    = cb - 1'b1;
		job.ic    = cc - 1'b1;
		job.cen_x = sx[CW-1:0];
		job.cen_y = sy[CW-1:0];
		job.cen_z = sz[CW-1:0];
	end

	assign wr_en   = acc && in_data.cmd == CMD_VERTEX && count_q < CNTW'(MAX_VERTICES);
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = {in_data.coord_x, in_data.coord_y, in_data.coord_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			empty_q <= 1'b1;
			min_x_q <= '0; max_x_q <= '0;
			min_y_q <= '0; max_y_q <= '0;
			min_z_q <= '0; max_z_q <= '0;
		end else if (acc) begin
			case (in_data.cmd)
				CMD_VERTEX: begin
					if (wr_en)
						count_q <= count_q + 1'b1;
					empty_q <= 1'b0;
					if (empty_q || in_data.coord_x < min_x_q) min_x_q <= in_data.coord_x;
					if (empty_q || in_data.coord_x > max_x_q) max_x_q <= in_data.coord_x;
					if (empty_q || in_data.coord_y < min_y_q) min_y_q <= in_data.coord_y;
					if (empty_q || in_data.coord_y > max_y_q) max_y_q <= in_data.coord_y;
					if (empty_q || in_data.coord_z < min_z_q) min_z_q <= in_data.coord_z;
					if (empty_q || in_data.coord_z > max_z_q) max_z_q <= in_data.coord_z;
				end
				CMD_NEW: count_q <= '0;
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_VERTICES))
		else $error("vertex count past table size");
	assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_data.cmd == CMD_VERTEX |=> !empty_q)
		else $error("box still empty after vertex");
	assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_data.cmd == CMD_NEW |=> count_q == '0)
		else $error("new mesh did not clear count");
endmodule

// File: src/mfna_queue.sv
// Short job queue between the front and back parts. Uses mfna_pkg.
module mfna_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  mfna_pkg::job_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output mfna_pkg::job_t rd_data
);
	import mfna_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic          push, pop;

	assign wr_ready = cnt_q != (PW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(DEPTH))
		else $error("queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count lost a push");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count lost a pop");
endmodule

// File: src/mfna_back.sv
// Back part: owns the vertex table, fetches a face's vertices, computes the
// unit normal with an iterative square root and restoring divides, and emits
// results through an output register. Uses mfna_pkg.
module mfna_back #(
	parameter int AW = 14,
	parameter int MAX_VERTICES = 16384
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [3*mfna_pkg::CW-1:0] wr_data,
	input  logic              job_valid,
	output logic              job_ready,
	input  mfna_pkg::job_t    job,
	output logic              out_valid,
	input  logic              out_ready,
	output mfna_pkg::out_item_t out_data
);
	import mfna_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_DIFF = 4'd2;
	localparam logic [3:0] ST_RED1 = 4'd3;
	localparam logic [3:0] ST_MUL  = 4'd4;
	localparam logic [3:0] ST_CRS  = 4'd5;
	localparam logic [3:0] ST_RED2 = 4'd6;
	localparam logic [3:0] ST_SQ   = 4'd7;
	localparam logic [3:0] ST_SQRT = 4'd8;
	localparam logic [3:0] ST_DIV  = 4'd9;
	localparam logic [3:0] ST_EMIT = 4'd10;
	localparam logic [3:0] ST_ONE  = 4'd11;

	localparam int ONE = 1 << (NW-1);

	logic [3*CW-1:0] table_mem [MAX_VERTICES];
	logic [3*CW-1:0] rd_q;
	logic [AW-1:0]   rd_addr;

	logic [3:0]  state_q;
	logic [1:0]  k_q;           // fetch / square / divide / emit index
	logic [5:0]  it_q;          // iteration counter
	logic [CW-1:0] v_q [3][3];
	logic signed [CW:0]  d_q [6];
	logic [29:0] dm_q [6];
	logic        dn_q [6];
	logic signed [61:0] pr_q [6];
	logic signed [62:0] cr_q [3];
	logic [29:0] cm_q [3];
	logic        cn_q [3];
	logic [61:0] sum_q;
	// sqrt
	logic [63:0] rem_q, root_q;
	logic [31:0] len_q;
	// divide
	logic [47:0] num_q;
	logic [31:0] quo_q;
	logic [32:0] drem_q;
	logic [NW-1:0] nrm_q [3];
	out_item_t   obuf_q;
	logic        ovalid_q;
	out_item_t   res;
	logic        emit;

	// memory
	always_ff @(posedge clk) begin
		if (wr_en)
			table_mem[wr_addr] <= wr_data;
		rd_q <= table_mem[rd_addr];
	end

	always_comb begin
		case (k_q)
			2'd0:    rd_addr = job.ia[AW-1:0];
			2'd1:    rd_addr = job.ib[AW-1:0];
			default: rd_addr = job.ic[AW-1:0];
		endcase
	end

	assign emit = (state_q == ST_ONE || state_q == ST_EMIT) && (!ovalid_q || out_ready);
	assign out_valid = ovalid_q;
	assign out_data  = obuf_q;
	assign job_ready = emit && (state_q == ST_ONE || k_q == 2'd2);

	always_comb begin
		res = '0;
		if (state_q == ST_ONE) begin
			res.last = 1'b1;
			if (job.kind == JOB_BAD)
				res.status = 1'b1;
			else begin
				res.center_x = job.cen_x;
				res.center_y = job.cen_y;
				res.center_z = job.cen_z;
			end
		end else begin
			res.vert_x = v_q[k_q][0];
			res.vert_y = v_q[k_q][1];
			res.vert_z = v_q[k_q][2];
			res.norm_x = nrm_q[0];
			res.norm_y = nrm_q[1];
			res.norm_z = nrm_q[2];
			res.last   = (k_q == 2'd2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (emit)
			ovalid_q <= 1'b1;
		else if (out_ready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit)
			obuf_q <= res;
	end

	// reduction amount: smallest shift bringing every magnitude below 2^30
	function automatic logic [5:0] red_shift(input logic [63:0] all);
		logic [5:0] s;
		s = 6'd0;
		for (int b = 30; b < 64; b++)
			if (all[b]) s = 6'(b - 29);
		return s;
	endfunction

	logic [63:0] or1, or2;
	logic [63:0] mag1 [6];
	logic [63:0] mag2 [3];
	always_comb begin
		or1 = '0;
		for (int i = 0; i < 6; i++) begin
			mag1[i] = d_q[i][CW] ? 64'(-d_q[i]) : 64'(d_q[i]);
			or1 = or1 | mag1[i];
		end
		or2 = '0;
		for (int i = 0; i < 3; i++) begin
			mag2[i] = cr_q[i][62] ? 64'(-cr_q[i]) : 64'(cr_q[i]);
			or2 = or2 | mag2[i];
		end
	end

	logic [63:0] trial;
	assign trial = root_q + (64'd1 << {it_q, 1'b0});
	logic [32:0] dtry;
	assign dtry = {drem_q[31:0], num_q[47]};
	logic qbit;
	assign qbit = (len_q != 0) && (dtry >= {1'b0, len_q});

	function automatic logic signed [30:0] sv(input logic n, input logic [29:0] m);
		return n ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	logic signed [30:0] pa [6], pb [6];
	always_comb begin
		pa[0] = sv(dn_q[1], dm_q[1]); pb[0] = sv(dn_q[5], dm_q[5]);
		pa[1] = sv(dn_q[2], dm_q[2]); pb[1] = sv(dn_q[4], dm_q[4]);
		pa[2] = sv(dn_q[2], dm_q[2]); pb[2] = sv(dn_q[3], dm_q[3]);
		pa[3] = sv(dn_q[0], dm_q[0]); pb[3] = sv(dn_q[5], dm_q[5]);
		pa[4] = sv(dn_q[0], dm_q[0]); pb[4] = sv(dn_q[4], dm_q[4]);
		pa[5] = sv(dn_q[1], dm_q[1]); pb[5] = sv(dn_q[3], dm_q[3]);
	end
	logic signed [61:0] mulp;
	logic [2:0] mi_q;
	assign mulp = pa[mi_q] * pb[mi_q];
	logic [59:0] sqp;
	assign sqp = cm_q[k_q] * cm_q[k_q];

	logic [5:0] s1, s2;
	assign s1 = red_shift(or1);
	assign s2 = red_shift(or2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			it_q     <= '0;
			mi_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (job_valid) begin
					k_q <= '0;
					state_q <= (job.kind == JOB_FACE) ? ST_RD : ST_ONE;
				end
				ST_ONE: if (emit)
					state_q <= ST_IDLE;
				ST_RD: begin
					// read data of k_q-1 arrives now
					if (it_q != 0)
						{v_q[k_q-1][0], v_q[k_q-1][1], v_q[k_q-1][2]} <= rd_q;
					if (it_q == 6'd3) begin
						state_q <= ST_DIFF;
						it_q <= '0;
					end else begin
						it_q <= it_q + 1'b1;
						if (it_q != 0 || k_q == 0) k_q <= (it_q == 0) ? 2'd1 : k_q + 1'b1;
					end
				end
				ST_DIFF: begin
					for (int j = 0; j < 3; j++) begin
						d_q[j]   <= $signed({v_q[1][j][CW-1], v_q[1][j]})
							- $signed({v_q[0][j][CW-1], v_q[0][j]});
						d_q[3+j] <= $signed({v_q[2][j][CW-1], v_q[2][j]})
							- $signed({v_q[0][j][CW-1], v_q[0][j]});
					end
					state_q <= ST_RED1;
				end
				ST_RED1: begin
					for (int i = 0; i < 6; i++) begin
						dm_q[i] <= 30'(mag1[i] >> s1);
						dn_q[i] <= d_q[i][CW];
					end
					mi_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					pr_q[mi_q] <= mulp;
					if (mi_q == 3'd5) state_q <= ST_CRS;
					else mi_q <= mi_q + 1'b1;
				end
				ST_CRS: begin
					cr_q[0] <= 63'(pr_q[0]) - 63'(pr_q[1]);
					cr_q[1] <= 63'(pr_q[2]) - 63'(pr_q[3]);
					cr_q[2] <= 63'(pr_q[4]) - 63'(pr_q[5]);
					state_q <= ST_RED2;
				end
				ST_RED2: begin
					for (int i = 0; i < 3; i++) begin
						cm_q[i] <= 30'(mag2[i] >> s2);
						cn_q[i] <= cr_q[i][62] && ((mag2[i] >> s2) != 0);
					end
					k_q <= '0;
					sum_q <= '0;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					sum_q <= sum_q + 62'(sqp);
					if (k_q == 2'd2) begin
						state_q <= ST_SQRT;
						it_q <= 6'd31;
						root_q <= '0;
						rem_q <= 64'(sum_q + 62'(sqp));
					end else k_q <= k_q + 1'b1;
				end
				ST_SQRT: begin
					// one result bit per cycle, bit = 4^it
					if (rem_q >= trial) begin
						rem_q  <= rem_q - trial;
						root_q <= (root_q >> 1) + (64'd1 << {it_q, 1'b0});
					end else
						root_q <= root_q >> 1;
					if (it_q == 0) begin
						len_q <= (rem_q >= trial) ? 32'((root_q >> 1) + 64'd1)
							: 32'(root_q >> 1);
						k_q <= '0;
						it_q <= 6'd47;
						num_q <= 48'(cm_q[0]) << (NW-1);
						drem_q <= '0;
						state_q <= ST_DIV;
					end else it_q <= it_q - 1'b1;
				end
				ST_DIV: begin
					// restoring divide, one quotient bit per cycle
					if (it_q == 0) begin
						// round half up on remainder, saturate
						begin
							logic [32:0] rr;
							logic [32:0] q1;
							logic [NW-1:0] qs;
							rr = (len_q == 0) ? '0 : (qbit ? dtry - {1'b0, len_q} : dtry);
							q1 = {quo_q, qbit};
							if (len_q != 0 && {rr[31:0], 1'b0} >= {1'b0, len_q}) q1 = q1 + 1'b1;
							if (len_q == 0) q1 = '0;
							qs = (q1 > 33'(ONE - 1)) ? NW'(ONE - 1) : NW'(q1);
							nrm_q[k_q] <= cn_q[k_q] ? NW'(-qs) : qs;
						end
						if (k_q == 2'd2) begin
							k_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							k_q <= k_q + 1'b1;
							it_q <= 6'd47;
							num_q <= 48'(cm_q[k_q+1]) << (NW-1);
							drem_q <= '0;
						end
					end else begin
						num_q <= num_q << 1;
						drem_q <= (len_q == 0) ? '0 : (qbit ? dtry - {1'b0, len_q} : dtry);
						quo_q <= (it_q == 6'd47) ? 32'(qbit) : {quo_q[30:0], qbit};
						it_q <= it_q - 1'b1;
					end
				end
				ST_EMIT: if (emit) begin
					if (k_q == 2'd2) state_q <= ST_IDLE;
					else k_q <= k_q + 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !out_ready |=> ovalid_q && $stable(obuf_q))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		job_ready |-> job_valid)
		else $error("job popped without a job");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE && state_q != ST_ONE |-> job_valid && job.kind == JOB_FACE)
		else $error("face work without a face job");
endmodule

// File: test/mfna_checker.sv
`timescale 1ns / 1ps
// Checker for mesh_face_normal_assembler_unit: watches both channels, predicts each
// result from the accepted requests and compares field by field. Uses mfna_pkg.
module mfna_checker
	import mfna_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        errors,
	output int        pending
);

	localparam int TABLE_DEPTH = MAX_VERTICES_DEF;
	localparam longint LIM30 = 64'd1 << 30;

	logic signed [CW-1:0] tab_x [TABLE_DEPTH];
	logic signed [CW-1:0] tab_y [TABLE_DEPTH];
	logic signed [CW-1:0] tab_z [TABLE_DEPTH];
	int unsigned          mesh_count = 0;
	longint               lo_x = 0, hi_x = 0, lo_y = 0, hi_y = 0, lo_z = 0, hi_z = 0;
	bit                   box_blank = 1'b1;
	int                   mismatches = 0;
	out_item_t            expected_results[$];

	assign pending = expected_results.size();
	assign errors = mismatches;

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// common right shift of magnitudes until all are below 2^30
	function automatic void shrink_mags(inout longint v[6], input int cnt);
		longint all_bits;
		int sh;
		longint m;
		all_bits = 0;
		sh = 0;
		for (int i = 0; i < cnt; i++) all_bits |= mag(v[i]);
		while ((all_bits >> sh) >= LIM30) sh++;
		for (int i = 0; i < cnt; i++) begin
			m = mag(v[i]) >> sh;
			v[i] = (v[i] < 0) ? -m : m;
		end
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void unit_normal(input int ia, input int ib, input int ic,
			output logic signed [NW-1:0] nx, output logic signed [NW-1:0] ny,
			output logic signed [NW-1:0] nz);
		longint d[6];
		longint cr[6];
		longint q[3];
		longint unsigned sum, len, one;
		one = 64'd1 << (NW - 1);
		d[0] = longint'(tab_x[ib]) - longint'(tab_x[ia]);
		d[1] = longint'(tab_y[ib]) - longint'(tab_y[ia]);
		d[2] = longint'(tab_z[ib]) - longint'(tab_z[ia]);
		d[3] = longint'(tab_x[ic]) - longint'(tab_x[ia]);
		d[4] = longint'(tab_y[ic]) - longint'(tab_y[ia]);
		d[5] = longint'(tab_z[ic]) - longint'(tab_z[ia]);
		shrink_mags(d, 6);
		cr[0] = d[1] * d[5] - d[2] * d[4];
		cr[1] = d[2] * d[3] - d[0] * d[5];
		cr[2] = d[0] * d[4] - d[1] * d[3];
		cr[3] = 0; cr[4] = 0; cr[5] = 0;
		shrink_mags(cr, 3);
		sum = 0;
		for (int i = 0; i < 3; i++) sum += mag(cr[i]) * mag(cr[i]);
		len = floor_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q[i] = 0;
			if (len != 0) begin
				q[i] = (longint'(mag(cr[i])) * one + len / 2) / len;
				if (q[i] > one - 1) q[i] = one - 1;
			end
			if (cr[i] < 0) q[i] = -q[i];
		end
		nx = q[0][NW-1:0];
		ny = q[1][NW-1:0];
		nz = q[2][NW-1:0];
	endfunction

	function automatic void widen(longint v, inout longint lo, inout longint hi);
		if (box_blank) begin
			lo = v;
			hi = v;
		end else begin
			if (v < lo) lo = v;
			if (v > hi) hi = v;
		end
	endfunction

	task automatic predict_request(in_item_t rq);
		out_item_t r;
		int ix[3];
		logic signed [NW-1:0] nx, ny, nz;
		bit bad;
		r = '0;
		case (rq.cmd)
			CMD_VERTEX: begin
				if (mesh_count < TABLE_DEPTH) begin
					tab_x[mesh_count] = rq.coord_x;
					tab_y[mesh_count] = rq.coord_y;
					tab_z[mesh_count] = rq.coord_z;
					mesh_count++;
				end
				widen(rq.coord_x, lo_x, hi_x);
				widen(rq.coord_y, lo_y, hi_y);
				widen(rq.coord_z, lo_z, hi_z);
				box_blank = 1'b0;
			end
			CMD_NEW: mesh_count = 0;
			CMD_QUERY: begin
				r.last = 1'b1;
				r.center_x = CW'((lo_x + hi_x) >>> 1);
				r.center_y = CW'((lo_y + hi_y) >>> 1);
				r.center_z = CW'((lo_z + hi_z) >>> 1);
				expected_results.push_back(r);
			end
			default: begin
				ix[0] = int'(rq.index_a);
				ix[1] = int'(rq.index_b);
				ix[2] = int'(rq.index_c);
				bad = 1'b0;
				for (int k = 0; k < 3; k++)
					if (ix[k] == 0 || ix[k] > mesh_count) bad = 1'b1;
				if (bad) begin
					r.last = 1'b1;
					r.status = 1'b1;
					expected_results.push_back(r);
				end else begin
					unit_normal(ix[0] - 1, ix[1] - 1, ix[2] - 1, nx, ny, nz);
					for (int k = 0; k < 3; k++) begin
						r = '0;
						r.vert_x = tab_x[ix[k] - 1];
						r.vert_y = tab_y[ix[k] - 1];
						r.vert_z = tab_z[ix[k] - 1];
						r.norm_x = nx;
						r.norm_y = ny;
						r.norm_z = nz;
						r.last = (k == 2);
						expected_results.push_back(r);
					end
				end
			end
		endcase
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result(out_item_t got);
		out_item_t w;
		if (expected_results.size() == 0) begin
			$display("%0t unexpected result: expected none actual %p", $time, got);
			mismatches++;
			return;
		end
		w = expected_results.pop_front();
		check_field("vert_x", w.vert_x, got.vert_x);
		check_field("vert_y", w.vert_y, got.vert_y);
		check_field("vert_z", w.vert_z, got.vert_z);
		check_field("norm_x", w.norm_x, got.norm_x);
		check_field("norm_y", w.norm_y, got.norm_y);
		check_field("norm_z", w.norm_z, got.norm_z);
		check_field("last", w.last, got.last);
		check_field("status", w.status, got.status);
		check_field("center_x", w.center_x, got.center_x);
		check_field("center_y", w.center_y, got.center_y);
		check_field("center_z", w.center_z, got.center_z);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			// results first: a result can never stem from a request taken at the same edge
			if (out_valid && out_ready) check_result(out_data);
			if (in_valid && in_ready) predict_request(in_data);
		end
	end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench for mesh_face_normal_assembler_unit: clock, reset, request
// stimulus with bursts and pauses, receiver stalls and the verdict. Uses mfna_pkg, mfna_checker.
module testbench;
	import mfna_pkg::*;

	localparam longint CYCLE_LIMIT = 500000;
	localparam int     RANDOM_REQUESTS = 270;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 0;
	out_item_t out_data;
	int        errors, pending;
	longint    cycles = 0;
	int        burst_left = 0;
	int        mesh_size = 0;
	bit        long_hold = 0;
	bit        hold_started = 0;
	int        hold_left = 0;
	int        stall_mode = 0;

	always #10 clk = ~clk;

	mesh_face_normal_assembler_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	mfna_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL mesh_face_normal_assembler_unit");
			$finish;
		end
	end

	// receiver: random stall pattern, redrawn periodically; one long hold when asked
	always @(posedge clk) begin
		if (long_hold && !hold_started) begin
			hold_started = 1'b1;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) != 0);
				2: out_ready <= ($urandom_range(0, 9) != 0);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return CW'($urandom);
			1: return CW'(int'($urandom_range(0, 8191)) - 4096);
			2: return CW'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return ($urandom_range(0, 1) != 0) ? {1'b0, {(CW-1){1'b1}}}
				: {1'b1, {(CW-1){1'b0}}};
		endcase
	endfunction

	function automatic in_item_t noise_item(logic [1:0] cmd);
		in_item_t it;
		it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom}));
		it.cmd = cmd;
		return it;
	endfunction

	// sender: bursts with random gaps; valid stays up across back-to-back requests
	task automatic send(in_item_t it, bit gaps = 1);
		if (gaps && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) burst_left--;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		case (it.cmd)
			CMD_VERTEX: if (mesh_size < MAX_VERTICES_DEF) mesh_size++;
			CMD_NEW: mesh_size = 0;
			default: ;
		endcase
	endtask

	task automatic send_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			logic signed [CW-1:0] z, bit gaps = 1);
		in_item_t it;
		it = noise_item(CMD_VERTEX);
		it.coord_x = x;
		it.coord_y = y;
		it.coord_z = z;
		send(it, gaps);
	endtask

	task automatic send_face(int a, int b, int c);
		in_item_t it;
		it = noise_item(CMD_FACE);
		it.index_a = INDEX_BITS'(a);
		it.index_b = INDEX_BITS'(b);
		it.index_c = INDEX_BITS'(c);
		send(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	initial begin
		logic signed [CW-1:0] hi_c, lo_c;
		int pick;
		hi_c = {1'b0, {(CW-1){1'b1}}};
		lo_c = {1'b1, {(CW-1){1'b0}}};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty box, faces with no vertices, extremes, degenerate, bad indices
		send(noise_item(CMD_QUERY));
		send_face(1, 2, 3);
		send_vertex(lo_c, lo_c, lo_c);
		send_vertex(hi_c, lo_c, lo_c);
		send_vertex(lo_c, hi_c, lo_c);
		send_vertex(hi_c, hi_c, hi_c);
		send_face(1, 2, 3);
		send_face(3, 2, 1);
		send_face(2, 3, 4);
		send_face(1, 1, 1);
		send_face(0, 2, 3);
		send_face(1, 5, 3);
		send_face(1, 2, 32767);
		send(noise_item(CMD_QUERY));
		send(noise_item(CMD_NEW));
		send_face(1, 2, 3);
		send_vertex(CW'(4096), '0, '0);
		send_vertex('0, CW'(4096), '0);
		send_vertex('0, '0, CW'(4096));
		send_vertex(CW'(8192), '0, '0);
		send_face(1, 2, 3);
		send_face(1, 2, 4);
		send(noise_item(CMD_QUERY));
		drain();

		// random: mostly well-formed meshes, some noise
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == 100) drain();
			if (n == 150) long_hold = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 5) send(noise_item(CMD_NEW));
			else if (pick < 13) send(noise_item(CMD_QUERY));
			else if (pick < 20) send_face($urandom_range(0, 32767), $urandom_range(0, 32767),
				$urandom_range(0, mesh_size + 1));
			else if (mesh_size < 3 || pick < 60) send_vertex(rand_coord(), rand_coord(), rand_coord());
			else send_face($urandom_range(1, mesh_size), $urandom_range(1, mesh_size),
				$urandom_range(1, mesh_size));
		end
		drain();

		if (errors == 0) begin
			$display("PASS mesh_face_normal_assembler_unit");
		end else begin
			$display("FAIL mesh_face_normal_assembler_unit");
		end
		$finish;
	end

endmodule
